### rtl/ssp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  localparam int FRAC_BITS = 16;
  localparam longint FX_ONE = 64'sd1 << FRAC_BITS;
  localparam longint FX_EPS = (FX_ONE + 50000) / 100000;

  // magnitude of a numerator of the form value * one
  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int ROOT_STEPS = 32;
  localparam int CNT_W = $clog2(NUM_W);

  localparam int OUT_W = 17;
  localparam logic [OUT_W-1:0] OUT_HALF = OUT_W'(32768);
  localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_L = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

  localparam logic signed [31:0] SUN_DIST = 32'sd1000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_MUL,
    OP_SQ_ACC,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIR_STORE,
    OP_NDC_STORE,
    OP_PT_MUL,
    OP_PT_ACC,
    OP_CLIP_INIT,
    OP_CLIP_MUL,
    OP_CLIP_ACC,
    OP_CLIP_STORE,
    OP_FINAL,
    OP_FAIL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx_i;
    logic [1:0] idx_j;
    logic       ndc;
  } cmd_t;

  typedef struct packed {
    logic len_small;
    logic w_small;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/ssp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ssp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] camera_x;
  logic signed [31:0] camera_y;
  logic signed [31:0] camera_z;
  logic signed [31:0] light_x;
  logic signed [31:0] light_y;
  logic signed [31:0] light_z;

  modport source (
    output valid, kind, element_index, element_value,
           camera_x, camera_y, camera_z, light_x, light_y, light_z,
    input  ready
  );
  modport sink (
    input  valid, kind, element_index, element_value,
           camera_x, camera_y, camera_z, light_x, light_y, light_z,
    output ready
  );
endinterface

`default_nettype wire

### rtl/ssp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] sun_u;
  logic [16:0] sun_v;
  logic        sun_visible;

  modport source (output valid, sun_u, sun_v, sun_visible, input ready);
  modport sink (input valid, sun_u, sun_v, sun_visible, output ready);
endinterface

`default_nettype wire

### rtl/ssp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ssp_datapath
  import ssp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               kind,
  input  wire logic [3:0]         element_index,
  input  wire logic signed [31:0] element_value,
  input  wire logic signed [31:0] camera_x,
  input  wire logic signed [31:0] camera_y,
  input  wire logic signed [31:0] camera_z,
  input  wire logic signed [31:0] light_x,
  input  wire logic signed [31:0] light_y,
  input  wire logic signed [31:0] light_z,
  output logic [OUT_W-1:0]        sun_u,
  output logic [OUT_W-1:0]        sun_v,
  output logic                    sun_visible
);

  logic signed [31:0] mat [16];
  logic signed [31:0] cam [3];
  logic signed [31:0] lit [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] pt [3];
  logic signed [31:0] clip [4];
  logic signed [31:0] ndc [2];

  logic signed [63:0] prod;
  logic [63:0]        sumsq;
  logic [63:0]        rx;
  logic [63:0]        rres;
  logic [63:0]        rbit;

  logic [NUM_W-1:0]   dnum;
  logic [NUM_W-1:0]   dquo;
  logic [32:0]        drem;
  logic [31:0]        dden;
  logic               dneg;

  logic signed [63:0] acc;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic [63:0]        root_try;
  logic [32:0]        rem_sh;
  logic signed [31:0] div_src;
  logic [31:0]        div_mag;
  logic signed [63:0] q_abs;
  logic signed [63:0] q_sig;
  logic signed [63:0] u_val;
  logic signed [63:0] v_val;
  logic [63:0]        u_bits;
  logic [63:0]        v_bits;
  logic               in_range;
  logic [3:0]         mat_idx;
  logic [3:0]         bias_idx;

  assign mat_idx  = {cmd.idx_i, cmd.idx_j};
  assign bias_idx = {2'd3, cmd.idx_j};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ_MUL: begin
        mul_a = lit[cmd.idx_i];
        mul_b = lit[cmd.idx_i];
      end
      OP_PT_MUL: begin
        mul_a = dir[cmd.idx_i];
        mul_b = SUN_DIST;
      end
      OP_CLIP_MUL: begin
        mul_a = pt[cmd.idx_i];
        mul_b = mat[mat_idx];
      end
      default: begin
      end
    endcase
  end

  assign root_try = rres + rbit;
  assign rem_sh   = {drem[31:0], dnum[NUM_W-1]};
  assign div_src  = cmd.ndc ? clip[cmd.idx_i] : lit[cmd.idx_i];
  assign div_mag  = div_src[31] ? 32'(-div_src) : 32'(div_src);
  assign q_abs    = $signed(64'(dquo));
  assign q_sig    = dneg ? -q_abs : q_abs;

  assign in_range = (ndc[0] >= -32'(FX_ONE)) && (ndc[0] <= 32'(FX_ONE)) &&
                    (ndc[1] >= -32'(FX_ONE)) && (ndc[1] <= 32'(FX_ONE));
  assign u_val  = (FX_ONE / 2) + (64'(ndc[0]) >>> 1);
  assign v_val  = (FX_ONE / 2) - (64'(ndc[1]) >>> 1);
  assign u_bits = (64'(u_val) >> SH_R) << SH_L;
  assign v_bits = (64'(v_val) >> SH_R) << SH_L;

  assign sts.len_small = rres <= 64'(FX_EPS);
  assign sts.w_small   = 64'(clip[3]) <= FX_EPS;

  // matrix store, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) begin
        mat[k] <= '0;
      end
    end else if (cmd.op == OP_LOAD && !kind) begin
      mat[element_index] <= element_value;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        cam[0] <= camera_x;
        cam[1] <= camera_y;
        cam[2] <= camera_z;
        lit[0] <= light_x;
        lit[1] <= light_y;
        lit[2] <= light_z;
        sumsq  <= '0;
      end
      OP_SQ_MUL, OP_PT_MUL, OP_CLIP_MUL: begin
        prod <= mul_a * mul_b;
      end
      OP_SQ_ACC: begin
        sumsq <= sumsq + 64'(prod);
      end
      OP_ROOT_INIT: begin
        rx   <= sumsq;
        rres <= '0;
        rbit <= 64'd1 << 62;
      end
      OP_ROOT_STEP: begin
        if (rx >= root_try) begin
          rx   <= rx - root_try;
          rres <= (rres >> 1) + rbit;
        end else begin
          rres <= rres >> 1;
        end
        rbit <= rbit >> 2;
      end
      OP_DIV_INIT: begin
        // direction is negated, so a positive light component gives a negative quotient
        dneg <= cmd.ndc ? div_src[31] : (!div_src[31] && div_src != 0);
        dden <= cmd.ndc ? 32'(clip[3]) : rres[31:0];
        dnum <= NUM_W'(div_mag) << FRAC_BITS;
        drem <= '0;
        dquo <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, dden}) begin
          drem <= rem_sh - {1'b0, dden};
          dquo <= {dquo[NUM_W-2:0], 1'b1};
        end else begin
          drem <= rem_sh;
          dquo <= {dquo[NUM_W-2:0], 1'b0};
        end
        dnum <= dnum << 1;
      end
      OP_DIR_STORE: begin
        dir[cmd.idx_i] <= q_sig[31:0];
      end
      OP_NDC_STORE: begin
        ndc[cmd.idx_i[0]] <= sat32(q_sig);
      end
      OP_PT_ACC: begin
        pt[cmd.idx_i] <= sat32(64'(cam[cmd.idx_i]) + prod);
      end
      OP_CLIP_INIT: begin
        acc <= 64'(mat[bias_idx]);
      end
      OP_CLIP_ACC: begin
        acc <= acc + (prod >>> FRAC_BITS);
      end
      OP_CLIP_STORE: begin
        clip[cmd.idx_j] <= sat32(acc);
      end
      OP_FINAL: begin
        if (in_range) begin
          sun_u       <= u_bits[OUT_W-1:0];
          sun_v       <= v_bits[OUT_W-1:0];
          sun_visible <= 1'b1;
        end else begin
          sun_u       <= OUT_HALF;
          sun_v       <= OUT_HALF;
          sun_visible <= 1'b0;
        end
      end
      OP_FAIL: begin
        sun_u       <= OUT_HALF;
        sun_v       <= OUT_HALF;
        sun_visible <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/ssp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ssp_ctrl
  import ssp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_kind,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  typedef enum logic [17:0] {
    S_IDLE       = 18'b000000000000000001,
    S_SQ_MUL     = 18'b000000000000000010,
    S_SQ_ACC     = 18'b000000000000000100,
    S_ROOT_INIT  = 18'b000000000000001000,
    S_ROOT       = 18'b000000000000010000,
    S_CHK_LEN    = 18'b000000000000100000,
    S_DIV_INIT   = 18'b000000000001000000,
    S_DIV        = 18'b000000000010000000,
    S_DIV_DONE   = 18'b000000000100000000,
    S_PT_MUL     = 18'b000000001000000000,
    S_PT_ACC     = 18'b000000010000000000,
    S_CLIP_INIT  = 18'b000000100000000000,
    S_CLIP_MUL   = 18'b000001000000000000,
    S_CLIP_ACC   = 18'b000010000000000000,
    S_CLIP_STORE = 18'b000100000000000000,
    S_CHK_W      = 18'b001000000000000000,
    S_FINAL      = 18'b010000000000000000,
    S_FAIL       = 18'b100000000000000000
  } state_t;

  state_t           state, state_next;
  logic [1:0]       ci, ci_next;
  logic [1:0]       cj, cj_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             ndc_phase, ndc_phase_next;
  logic             out_set;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    ci_next        = ci;
    cj_next        = cj;
    cnt_next       = cnt;
    ndc_phase_next = ndc_phase;
    out_set        = 1'b0;
    cmd.op         = OP_NONE;
    cmd.idx_i      = ci;
    cmd.idx_j      = cj;
    cmd.ndc        = ndc_phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op         = OP_LOAD;
          ci_next        = '0;
          ndc_phase_next = 1'b0;
          if (in_kind) begin
            state_next = S_SQ_MUL;
          end
        end
      end
      S_SQ_MUL: begin
        cmd.op     = OP_SQ_MUL;
        state_next = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.op = OP_SQ_ACC;
        if (ci == 2'd2) begin
          state_next = S_ROOT_INIT;
        end else begin
          ci_next    = ci + 2'd1;
          state_next = S_SQ_MUL;
        end
      end
      S_ROOT_INIT: begin
        cmd.op     = OP_ROOT_INIT;
        cnt_next   = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.op   = OP_ROOT_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          state_next = S_CHK_LEN;
        end
      end
      S_CHK_LEN: begin
        ci_next    = '0;
        state_next = sts.len_small ? S_FAIL : S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          state_next = S_DIV_DONE;
        end
      end
      S_DIV_DONE: begin
        if (ndc_phase) begin
          cmd.op = OP_NDC_STORE;
          if (ci == 2'd1) begin
            state_next = S_FINAL;
          end else begin
            ci_next    = 2'd1;
            state_next = S_DIV_INIT;
          end
        end else begin
          cmd.op     = OP_DIR_STORE;
          state_next = S_PT_MUL;
        end
      end
      S_PT_MUL: begin
        cmd.op     = OP_PT_MUL;
        state_next = S_PT_ACC;
      end
      S_PT_ACC: begin
        cmd.op = OP_PT_ACC;
        if (ci == 2'd2) begin
          cj_next    = '0;
          state_next = S_CLIP_INIT;
        end else begin
          ci_next    = ci + 2'd1;
          state_next = S_DIV_INIT;
        end
      end
      S_CLIP_INIT: begin
        cmd.op     = OP_CLIP_INIT;
        ci_next    = '0;
        state_next = S_CLIP_MUL;
      end
      S_CLIP_MUL: begin
        cmd.op     = OP_CLIP_MUL;
        state_next = S_CLIP_ACC;
      end
      S_CLIP_ACC: begin
        cmd.op = OP_CLIP_ACC;
        if (ci == 2'd2) begin
          state_next = S_CLIP_STORE;
        end else begin
          ci_next    = ci + 2'd1;
          state_next = S_CLIP_MUL;
        end
      end
      S_CLIP_STORE: begin
        cmd.op = OP_CLIP_STORE;
        if (cj == 2'd3) begin
          state_next = S_CHK_W;
        end else begin
          cj_next    = cj + 2'd1;
          state_next = S_CLIP_INIT;
        end
      end
      S_CHK_W: begin
        ci_next        = '0;
        ndc_phase_next = 1'b1;
        state_next     = sts.w_small ? S_FAIL : S_DIV_INIT;
      end
      S_FINAL: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd.op     = OP_FINAL;
          out_set    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FAIL: begin
        if (out_free) begin
          cmd.op     = OP_FAIL;
          out_set    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ci        <= '0;
      cj        <= '0;
      cnt       <= '0;
      ndc_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ci        <= ci_next;
      cj        <= cj_next;
      cnt       <= cnt_next;
      ndc_phase <= ndc_phase_next;
      out_valid <= out_set || (out_valid && !out_ready);
    end
  end

endmodule

`default_nettype wire

### rtl/sun_screen_projection_unit.sv
// channel  | dir | payload
// item     | in  | kind, element_index, element_value, camera_x/y/z, light_x/y/z
// result   | out | sun_u, sun_v, sun_visible
//
// a projection's run time is set by the one-bit-per-cycle square root (32 steps)
// and the shared restoring divider (32 + FRAC_BITS steps, five divisions) plus
// multiply/accumulate steps
// synchronous reset clears the matrix and the controller
// a finished result waits in the output register while the next request is taken
`timescale 1ns / 1ps
`default_nettype none

module sun_screen_projection_unit
  import ssp_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  ssp_in_if.sink   item,
  ssp_out_if.source result
);

  cmd_t cmd;
  sts_t sts;

  ssp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_kind   (item.kind),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ssp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (item.kind),
    .element_index (item.element_index),
    .element_value (item.element_value),
    .camera_x      (item.camera_x),
    .camera_y      (item.camera_y),
    .camera_z      (item.camera_z),
    .light_x       (item.light_x),
    .light_y       (item.light_y),
    .light_z       (item.light_z),
    .sun_u         (result.sun_u),
    .sun_v         (result.sun_v),
    .sun_visible   (result.sun_visible)
  );

endmodule

`default_nettype wire

### verif/sun_screen_projection_unit_tb.sv
`timescale 1ns / 1ps

module sun_screen_projection_unit_tb;
  import ssp_pkg::*;

  typedef struct {
    logic              kind;
    logic [3:0]        element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] cam [3];
    logic signed [31:0] light [3];
  } request_t;

  typedef struct {
    logic [16:0] u;
    logic [16:0] v;
    logic        vis;
  } sun_pos_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssp_in_if  item ();
  ssp_out_if result ();

  sun_screen_projection_unit dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  request_t pending_q[$];
  sun_pos_t sun_pos_q[$];
  longint   matrix_model[16];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_off = 0;
  bit       failed = 1'b0;
  int       idle_cycles = 0;

  function automatic longint sat32_m(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint div_trunc(longint num, longint den);
    longint q;
    q = (num < 0 ? -num : num) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [16:0] rescale_q16(longint v);
    logic [63:0] w;
    w = v;
    if (FRAC_BITS >= 16) w = w >> (FRAC_BITS - 16);
    else w = w << (16 - FRAC_BITS);
    return w[16:0];
  endfunction

  function automatic sun_pos_t project_sun(request_t r);
    sun_pos_t p;
    longint unsigned sumsq;
    longint len, nx, ny, acc, d;
    longint pt[4];
    longint clip[4];
    p.u = OUT_HALF;
    p.v = OUT_HALF;
    p.vis = 1'b0;
    sumsq = 0;
    for (int i = 0; i < 3; i++) sumsq += longint'(r.light[i]) * longint'(r.light[i]);
    len = int_sqrt(sumsq);
    if (len <= FX_EPS) return p;
    for (int i = 0; i < 3; i++) begin
      d = div_trunc(-longint'(r.light[i]) * FX_ONE, len);
      pt[i] = sat32_m(longint'(r.cam[i]) + d * 1000);
    end
    pt[3] = FX_ONE;
    for (int j = 0; j < 4; j++) begin
      acc = matrix_model[12 + j];
      for (int i = 0; i < 3; i++)
        acc += floor_sh(pt[i] * matrix_model[i * 4 + j], FRAC_BITS);
      clip[j] = sat32_m(acc);
    end
    if (clip[3] <= FX_EPS) return p;
    nx = sat32_m(div_trunc(clip[0] * FX_ONE, clip[3]));
    ny = sat32_m(div_trunc(clip[1] * FX_ONE, clip[3]));
    if (nx < -FX_ONE || nx > FX_ONE || ny < -FX_ONE || ny > FX_ONE) return p;
    p.u = rescale_q16(FX_ONE / 2 + floor_sh(nx, 1));
    p.v = rescale_q16(FX_ONE / 2 - floor_sh(ny, 1));
    p.vis = 1'b1;
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        r = pending_q.pop_front();
        if (r.kind == 1'b0) matrix_model[r.element_index] = r.element_value;
        else sun_pos_q.push_back(project_sun(r));
      end
      if (pending_q.size() > 0 && (item.valid && !item.ready ||
          $urandom_range(99) >= send_idle_pct)) begin
        r = pending_q[0];
        item.valid         <= 1'b1;
        item.kind          <= r.kind;
        item.element_index <= r.element_index;
        item.element_value <= r.element_value;
        item.camera_x      <= r.cam[0];
        item.camera_y      <= r.cam[1];
        item.camera_z      <= r.cam[2];
        item.light_x       <= r.light[0];
        item.light_y       <= r.light[1];
        item.light_z       <= r.light[2];
      end else begin
        item.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sun_pos_t e;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (sun_pos_q.size() == 0) begin
          $display("%t unexpected result u=%h v=%h vis=%b", $time,
                   result.sun_u, result.sun_v, result.sun_visible);
          failed <= 1'b1;
        end else begin
          e = sun_pos_q.pop_front();
          if (e.u !== result.sun_u || e.v !== result.sun_v ||
              e.vis !== result.sun_visible) begin
            $display("%t mismatch expected u=%h v=%h vis=%b actual u=%h v=%h vis=%b",
                     $time, e.u, e.v, e.vis, result.sun_u, result.sun_v,
                     result.sun_visible);
            failed <= 1'b1;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sun_screen_projection_unit_tb NOT OK");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_fx();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(32'h7fff)) - 32'sd16384;
      2: return 32'sh7fffffff;
      3: return 32'sh80000000;
      default: return $signed($urandom_range(32'h3ffff)) - 32'sd131072;
    endcase
  endfunction

  task automatic push_load(int idx, logic signed [31:0] val);
    request_t r;
    r.kind = 1'b0;
    r.element_index = idx[3:0];
    r.element_value = val;
    for (int i = 0; i < 3; i++) begin
      r.cam[i] = $urandom;
      r.light[i] = $urandom;
    end
    pending_q.push_back(r);
  endtask

  task automatic push_projection(logic signed [31:0] cx, logic signed [31:0] cy,
                                 logic signed [31:0] cz, logic signed [31:0] lx,
                                 logic signed [31:0] ly, logic signed [31:0] lz);
    request_t r;
    r.kind = 1'b1;
    r.element_index = 4'($urandom);
    r.element_value = $urandom;
    r.cam[0] = cx; r.cam[1] = cy; r.cam[2] = cz;
    r.light[0] = lx; r.light[1] = ly; r.light[2] = lz;
    pending_q.push_back(r);
  endtask

  // a scaled-down projection so that many sun points land on screen
  task automatic push_sane_matrix();
    int s;
    s = $urandom_range(8, 1);
    for (int k = 0; k < 16; k++) begin
      if (k == 15) push_load(k, 32'sd65536 * 1000 + $signed($urandom_range(2000000)));
      else if (k == 0 || k == 5) push_load(k, (32'sd65536 / s) + $signed($urandom_range(200)));
      else push_load(k, $signed($urandom_range(4000)) - 32'sd2000);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || sun_pos_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    item.valid = 1'b0;
    item.kind = 1'b0;
    item.element_index = '0;
    item.element_value = '0;
    item.camera_x = '0; item.camera_y = '0; item.camera_z = '0;
    item.light_x = '0; item.light_y = '0; item.light_z = '0;
    result.ready = 1'b0;
    for (int k = 0; k < 16; k++) matrix_model[k] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: zero matrix means w too small, short and zero directions
    push_projection(0, 0, 0, 0, 0, 0);
    push_projection(0, 0, 0, 1, 0, 0);
    push_projection(0, 0, 0, 0, 65536, 0);
    push_sane_matrix();
    push_projection(0, 0, 0, 0, 0, -65536);
    push_projection(0, 0, 0, 0, 0, 65536);
    push_projection(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    push_projection(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 32'sh80000000);
    push_projection(0, 0, 0, 65536, 65536, -65536);
    // negative w
    push_load(15, 32'sh80000000);
    push_projection(0, 0, 0, 0, 0, -65536);
    push_load(15, 32'sh7fffffff);
    push_projection(0, 0, 0, 0, 0, 65536);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 35 : 0;
      if (ph == 2) hold_off = 3000;
      for (int n = 0; n < 190; n++) begin
        case ($urandom_range(9))
          0: push_load($urandom_range(15), rand_fx());
          1: push_sane_matrix();
          2: push_projection(rand_fx(), rand_fx(), rand_fx(), rand_fx(), rand_fx(),
                             rand_fx());
          default: push_projection($signed($urandom_range(2000000)) - 32'sd1000000,
                                   $signed($urandom_range(2000000)) - 32'sd1000000,
                                   $signed($urandom_range(2000000)) - 32'sd1000000,
                                   rand_fx(), rand_fx(),
                                   32'sd65536 * 4 + $signed($urandom_range(65536 * 8)));
        endcase
        if (pending_q.size() > 20) while (pending_q.size() > 4) @(posedge clk);
      end
      wait_drained();
    end

    if (!failed) begin
      $display("sun_screen_projection_unit_tb OK");
    end else begin
      $display("sun_screen_projection_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
